@@ sv/rhh_pkg.sv @@
// Package with types, constants and helpers for the Robin Hood hash table.
`default_nettype none
package rhh_pkg;
	localparam int TABLE_BITS = 10;
	localparam int KEY_BYTES = 8;
	localparam int TABLE_SIZE = 1 << TABLE_BITS;
	localparam int PSL_W = 10;
	localparam logic [PSL_W-1:0] PSL_MAX = 10'd1023;
	localparam logic [31:0] GOLDEN = 32'h61C88647;

	localparam logic [1:0] FUNC_FIND = 2'd0;
	localparam logic [1:0] FUNC_ADD = 2'd1;
	localparam logic [1:0] FUNC_DEL = 2'd2;
	localparam logic [1:0] FUNC_RSVD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_EXISTS = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [0:0] REG_CASE = 1'd0;
	localparam logic [0:0] REG_BITS = 1'd1;

	typedef struct packed {
		logic [1:0] func;
		logic [31:0] hash_value;
		logic [63:0] key_bytes;
		logic [3:0] key_length;
		logic [63:0] value_in;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] value_out;
		logic [10:0] entries_held;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [31:0] hash;
		logic [63:0] key;
		logic [3:0] klen;
		logic [63:0] value;
		logic [PSL_W-1:0] psl;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_HOME, S_RD, S_CHK, S_INS_RD, S_INS_CHK, S_DEL_RD, S_DEL_CHK, S_DONE
	} state_t;

	typedef struct packed {
		logic clear_mem;
		logic load;
		logic home;
		logic rd_pos;
		logic rd_next;
		logic step;
		logic swap;
		logic write_carry;
		logic move_back;
		logic clear_cur;
		logic clr_iter;
		logic inc_count;
		logic dec_count;
		logic [1:0] status;
		logic take_value;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic valid;
		logic match;
		logic stop_find;
		logic rich;
		logic last;
		logic next_stop;
		logic init_last;
	} sts_t;

	function automatic logic [7:0] fold(input logic ci, input logic [7:0] c);
		fold = (ci && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction
endpackage
`default_nettype wire

@@ sv/robin_hood_hash_table.sv @@
// Top level of the Robin Hood hash table with its register port.
// After reset, busy stays high while the slot memory is cleared one slot per cycle.
// A request then reads and checks its probed slots one after another, up to the empty
// or stopping slot; an add that inserts walks its probe run again, and a delete that
// finds its key shifts entries back until a slot ends the shift. The walk over the
// single-port slot memory is serial. The result beat comes in the cycle in which busy
// falls, so the next request can be accepted at the edge that ends it, and the
// receiver cannot stall it.
`default_nettype none
module robin_hood_hash_table import rhh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire req_t req,
	output logic done,
	output rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic ci_q;
	logic [3:0] ib_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= 1'b0;
			ib_q <= 4'd10;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_CASE) begin
			ci_q <= pwdata[0];
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			ib_q <= pwdata[3:0];
		end
	end
	always_comb begin
		unique case (paddr[2])
			REG_CASE: prdata = {31'b0, ci_q};
			REG_BITS: prdata = {28'b0, ib_q};
			default: prdata = '0;
		endcase
	end

	rhh_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .cmd);
	rhh_dp u_dp (.clk, .arst_n, .req, .cmd, .case_insensitive(ci_q), .index_bits(ib_q),
		.sts, .done, .rsp);
endmodule
`default_nettype wire

@@ sv/rhh_ctrl.sv @@
// Controller state machine for the Robin Hood hash table.
`default_nettype none
module rhh_ctrl import rhh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire sts_t sts,
	output cmd_t cmd
);
	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_INIT: begin
				cmd.clear_mem = 1'b1;
				if (sts.init_last) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					nxt = S_HOME;
				end
			end
			S_HOME: begin
				cmd.home = 1'b1;
				nxt = S_RD;
			end
			S_RD: begin
				cmd.rd_pos = 1'b1;
				nxt = S_CHK;
			end
			S_CHK: begin
				if (sts.func == FUNC_ADD) begin
					if (!sts.valid) begin
						cmd.home = 1'b1;
						nxt = S_INS_RD;
					end else if (sts.match) begin
						cmd.status = ST_EXISTS;
						nxt = S_DONE;
					end else if (sts.last) begin
						cmd.status = ST_FULL;
						nxt = S_DONE;
					end else begin
						cmd.step = 1'b1;
						nxt = S_RD;
					end
				end else if (sts.func == FUNC_FIND || sts.func == FUNC_DEL) begin
					if (!sts.valid || sts.stop_find) begin
						cmd.status = ST_NOTFOUND;
						nxt = S_DONE;
					end else if (sts.match) begin
						if (sts.func == FUNC_FIND) begin
							cmd.status = ST_OK;
							cmd.take_value = 1'b1;
							nxt = S_DONE;
						end else begin
							cmd.dec_count = 1'b1;
							cmd.clr_iter = 1'b1;
							nxt = S_DEL_RD;
						end
					end else if (sts.last) begin
						cmd.status = ST_NOTFOUND;
						nxt = S_DONE;
					end else begin
						cmd.step = 1'b1;
						nxt = S_RD;
					end
				end else begin
					cmd.status = ST_NOTFOUND;
					nxt = S_DONE;
				end
			end
			S_INS_RD: begin
				cmd.rd_pos = 1'b1;
				nxt = S_INS_CHK;
			end
			S_INS_CHK: begin
				if (!sts.valid) begin
					cmd.write_carry = 1'b1;
					cmd.inc_count = 1'b1;
					cmd.status = ST_OK;
					nxt = S_DONE;
				end else begin
					cmd.swap = sts.rich;
					cmd.step = 1'b1;
					nxt = S_INS_RD;
				end
			end
			S_DEL_RD: begin
				cmd.rd_next = 1'b1;
				nxt = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				if (sts.next_stop || sts.last) begin
					cmd.clear_cur = 1'b1;
					cmd.status = ST_OK;
					nxt = S_DONE;
				end else begin
					cmd.move_back = 1'b1;
					cmd.step = 1'b1;
					nxt = S_DEL_RD;
				end
			end
			S_DONE: begin
				cmd.done = 1'b1;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ sv/rhh_dp.sv @@
// Datapath with the slot memory, carried entry and compare logic.
`default_nettype none
module rhh_dp import rhh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire req_t req,
	input wire cmd_t cmd,
	input wire logic case_insensitive,
	input wire logic [3:0] index_bits,
	output sts_t sts,
	output logic done,
	output rsp_t rsp
);
	entry_t mem [TABLE_SIZE];
	entry_t rd_q, carry_q;
	req_t req_q;
	logic [TABLE_BITS-1:0] pos_q, mask_q, clr_q;
	logic [TABLE_BITS:0] iter_q;
	logic [10:0] count_q;
	logic [31:0] prod_q;
	logic [3:0] bits_q;
	logic [1:0] status_q;
	logic [63:0] vout_q;
	logic done_q;
	logic [TABLE_BITS-1:0] nxtpos, addr, home;
	logic [TABLE_BITS:0] size;
	logic match;
	logic [3:0] nb;

	assign nxtpos = (pos_q + 1'b1) & mask_q;
	assign size = (TABLE_BITS+1)'(1) << bits_q;
	assign addr = cmd.rd_next ? nxtpos : pos_q;
	assign home = TABLE_BITS'(prod_q >> (6'd32 - {2'b0, bits_q}));

	always_comb begin
		match = (rd_q.hash == req_q.hash_value) && (rd_q.klen == req_q.key_length);
		nb = (req_q.key_length < 4'(KEY_BYTES)) ? req_q.key_length : 4'(KEY_BYTES);
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (4'(i) < nb && fold(case_insensitive, rd_q.key[8*i +: 8])
					!= fold(case_insensitive, req_q.key_bytes[8*i +: 8]))
				match = 1'b0;
		end
	end

	always_comb begin
		sts.func = req_q.func;
		sts.valid = rd_q.valid;
		sts.match = match;
		sts.stop_find = {1'b0, iter_q[TABLE_BITS-1:0]} > {1'b0, rd_q.psl} || iter_q[TABLE_BITS];
		sts.rich = carry_q.psl > rd_q.psl;
		sts.last = (iter_q + 1'b1) >= size;
		sts.next_stop = !rd_q.valid || rd_q.psl == '0;
		sts.init_last = &clr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_pos || cmd.rd_next) rd_q <= mem[addr];
		if (cmd.clear_mem) mem[clr_q] <= '0;
		else if (cmd.write_carry || cmd.swap) mem[pos_q] <= carry_q;
		else if (cmd.move_back) mem[pos_q] <= '{valid: 1'b1, hash: rd_q.hash, key: rd_q.key,
			klen: rd_q.klen, value: rd_q.value, psl: rd_q.psl - 1'b1};
		else if (cmd.clear_cur) mem[pos_q] <= '0;
		if (cmd.load) begin
			req_q <= req;
			prod_q <= req.hash_value * GOLDEN;
			if (index_bits == 4'd0) bits_q <= 4'd1;
			else if (index_bits > 4'(TABLE_BITS)) bits_q <= 4'(TABLE_BITS);
			else bits_q <= index_bits;
		end
		if (cmd.home) begin
			mask_q <= TABLE_BITS'(size - 1'b1);
			pos_q <= home;
			iter_q <= '0;
			carry_q <= '{valid: 1'b1, hash: req_q.hash_value, key: req_q.key_bytes,
				klen: req_q.key_length, value: req_q.value_in, psl: '0};
		end
		if (cmd.clr_iter) iter_q <= '0;
		if (cmd.step) begin
			pos_q <= nxtpos;
			iter_q <= iter_q + 1'b1;
			if (cmd.swap) carry_q <= '{valid: 1'b1, hash: rd_q.hash, key: rd_q.key,
				klen: rd_q.klen, value: rd_q.value,
				psl: (rd_q.psl < PSL_MAX) ? rd_q.psl + 1'b1 : rd_q.psl};
			else if (carry_q.psl < PSL_MAX) carry_q.psl <= carry_q.psl + 1'b1;
		end
		if (cmd.load) begin
			status_q <= ST_NOTFOUND;
			vout_q <= '0;
		end
		if (cmd.take_value) vout_q <= rd_q.value;
		if (cmd.write_carry || cmd.clear_cur || cmd.take_value || cmd.status != ST_OK)
			status_q <= cmd.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.clear_mem) clr_q <= clr_q + 1'b1;
			if (cmd.inc_count) count_q <= count_q + 1'b1;
			if (cmd.dec_count) count_q <= count_q - 1'b1;
		end
	end

	assign done = done_q;
	assign rsp.status = status_q;
	assign rsp.value_out = vout_q;
	assign rsp.entries_held = count_q;
endmodule
`default_nettype wire

@@ sv/rhh_checker.sv @@
// Port checker for the Robin Hood hash table and its bind.
`default_nettype none
module rhh_port_checker import rhh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("busy not raised after accept");
	a_done: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result beat longer than one cycle");
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.value_out == '0)
		else $error("value on failed request");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("busy during result beat");
endmodule
bind robin_hood_hash_table rhh_port_checker u_chk (.clk, .arst_n, .start, .busy, .done, .rsp);
`default_nettype wire

@@ tb/rhh_checker.sv @@
// Checker for the Robin Hood hash table: predicts each request's response and compares it.
module rhh_checker import rhh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output int fail_count,
	output int pending
);
	logic tbl_valid [TABLE_SIZE];
	logic [31:0] tbl_hash [TABLE_SIZE];
	logic [63:0] tbl_key [TABLE_SIZE];
	logic [3:0] tbl_klen [TABLE_SIZE];
	logic [63:0] tbl_value [TABLE_SIZE];
	logic [PSL_W-1:0] tbl_psl [TABLE_SIZE];
	int unsigned entry_cnt;
	logic cfg_fold;
	logic [3:0] cfg_bits;
	rsp_t expected_rsp [$];

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (cfg_fold && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic key_equal(input int s, input req_t r);
		int n;
		if (tbl_hash[s] != r.hash_value || tbl_klen[s] != r.key_length)
			return 1'b0;
		n = r.key_length < KEY_BYTES ? r.key_length : KEY_BYTES;
		for (int b = 0; b < n; b++)
			if (to_lower(tbl_key[s][8*b +: 8]) != to_lower(r.key_bytes[8*b +: 8]))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic apply_request(input req_t r, output rsp_t o);
		int bits, size, mask, home, pos, cur, nxt;
		logic [31:0] prod, ch, th;
		logic [63:0] ck, cv, tk, tv;
		logic [3:0] cl, tl;
		logic [PSL_W-1:0] cp, tp;
		logic found, empty, exists;
		bits = cfg_bits;
		if (bits < 1) bits = 1;
		if (bits > TABLE_BITS) bits = TABLE_BITS;
		size = 1 << bits;
		mask = size - 1;
		prod = r.hash_value * GOLDEN;
		home = prod >> (32 - bits);
		o = '0;
		o.status = ST_NOTFOUND;
		pos = home;
		if (r.func == FUNC_FIND || r.func == FUNC_DEL) begin
			found = 1'b0;
			for (int i = 0; i < size; i++) begin
				pos = (home + i) & mask;
				if (!tbl_valid[pos] || i > tbl_psl[pos]) break;
				if (key_equal(pos, r)) begin
					found = 1'b1;
					break;
				end
			end
			if (found && r.func == FUNC_FIND) begin
				o.status = ST_OK;
				o.value_out = tbl_value[pos];
			end else if (found) begin
				o.status = ST_OK;
				entry_cnt--;
				cur = pos;
				for (int s = 0; s + 1 < size; s++) begin
					nxt = (cur + 1) & mask;
					if (!tbl_valid[nxt] || tbl_psl[nxt] == 0) break;
					tbl_valid[cur] = tbl_valid[nxt];
					tbl_hash[cur] = tbl_hash[nxt];
					tbl_key[cur] = tbl_key[nxt];
					tbl_klen[cur] = tbl_klen[nxt];
					tbl_value[cur] = tbl_value[nxt];
					tbl_psl[cur] = tbl_psl[nxt] - 1'b1;
					cur = nxt;
				end
				tbl_valid[cur] = 1'b0;
			end
		end else if (r.func == FUNC_ADD) begin
			empty = 1'b0;
			exists = 1'b0;
			for (int i = 0; i < size; i++) begin
				pos = (home + i) & mask;
				if (!tbl_valid[pos]) begin
					empty = 1'b1;
					break;
				end
				if (key_equal(pos, r)) begin
					exists = 1'b1;
					break;
				end
			end
			if (exists) begin
				o.status = ST_EXISTS;
			end else if (!empty) begin
				o.status = ST_FULL;
			end else begin
				ch = r.hash_value;
				cl = r.key_length;
				ck = r.key_bytes;
				cv = r.value_in;
				cp = '0;
				for (int i = 0; i < size; i++) begin
					pos = (home + i) & mask;
					if (!tbl_valid[pos]) break;
					if (cp > tbl_psl[pos]) begin
						th = tbl_hash[pos]; tl = tbl_klen[pos]; tp = tbl_psl[pos];
						tk = tbl_key[pos]; tv = tbl_value[pos];
						tbl_hash[pos] = ch; tbl_klen[pos] = cl; tbl_psl[pos] = cp;
						tbl_key[pos] = ck; tbl_value[pos] = cv;
						ch = th; cl = tl; cp = tp; ck = tk; cv = tv;
					end
					if (cp < PSL_MAX) cp++;
				end
				tbl_valid[pos] = 1'b1;
				tbl_hash[pos] = ch;
				tbl_key[pos] = ck;
				tbl_klen[pos] = cl;
				tbl_value[pos] = cv;
				tbl_psl[pos] = cp;
				entry_cnt++;
				o.status = ST_OK;
			end
		end
		o.entries_held = entry_cnt[10:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) tbl_valid[i] = 1'b0;
			entry_cnt = 0;
			cfg_fold = 1'b0;
			cfg_bits = 4'd10;
			expected_rsp.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response beat with nothing expected: %h", $time, rsp);
					fail_count++;
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
						fail_count++;
					end
					if (rsp.value_out !== e.value_out) begin
						$display("%0t: value_out expected %h actual %h", $time, e.value_out,
							rsp.value_out);
						fail_count++;
					end
					if (rsp.entries_held !== e.entries_held) begin
						$display("%0t: entries_held expected %0d actual %0d", $time,
							e.entries_held, rsp.entries_held);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				apply_request(req, e);
				expected_rsp.push_back(e);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2:2] == REG_CASE) cfg_fold = pwdata[0];
				else cfg_bits = pwdata[3:0];
			end
		end
		pending = expected_rsp.size();
	end
endmodule

@@ tb/robin_hood_hash_table_tb.sv @@
// Testbench top for the Robin Hood hash table: stimulus, register writes and verdict.
module robin_hood_hash_table_tb;
	import rhh_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int cycles = 0;
	int sent = 0;
	int cfg_writes = 0;
	int idle_pct = 0;
	logic [31:0] pool_hash [16];
	logic [63:0] pool_key [16];
	logic [3:0] pool_len [16];

	robin_hood_hash_table i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rhh_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d responses outstanding.", pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic issue(input req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [0:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_writes++;
	endtask

	function automatic req_t mk(input logic [1:0] f, input logic [31:0] h, input logic [63:0] k,
			input logic [3:0] l, input logic [63:0] v);
		req_t r;
		r.func = f; r.hash_value = h; r.key_bytes = k; r.key_length = l; r.value_in = v;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic refill_pool();
		logic [7:0] c;
		for (int i = 0; i < 16; i++) begin
			pool_hash[i] = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5));
			pool_len[i] = 4'($urandom_range(1, 8));
			for (int b = 0; b < 8; b++) begin
				c = 8'($urandom_range('h41, 'h5A));
				if ($urandom_range(3) == 0) c = 8'($urandom);
				pool_key[i][8*b +: 8] = c;
			end
		end
	endtask

	function automatic req_t pool_req();
		req_t r;
		int p;
		int w;
		logic [7:0] c;
		p = $urandom_range(15);
		w = $urandom_range(99);
		r.func = w < 45 ? FUNC_ADD : (w < 75 ? FUNC_FIND : FUNC_DEL);
		r.hash_value = pool_hash[p];
		r.key_length = pool_len[p];
		r.key_bytes = pool_key[p];
		for (int b = 0; b < 8; b++) begin
			c = r.key_bytes[8*b +: 8];
			if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(3) == 0)
				r.key_bytes[8*b +: 8] = c ^ 8'h20;
		end
		r.value_in = rand64();
		return r;
	endfunction

	initial begin
		logic [3:0] bits_list [8] = '{4'd10, 4'd3, 4'd1, 4'd15, 4'd0, 4'd5, 4'd2, 4'd10};
		int pct_list [4] = '{0, 64, 0, 29};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk(FUNC_FIND, 32'h0, 64'h0, 4'd1, 64'h0));
		issue(mk(FUNC_ADD, 32'h0, 64'h0, 4'd1, '1));
		issue(mk(FUNC_ADD, 32'h0, 64'h0, 4'd1, 64'h5));
		issue(mk(FUNC_FIND, 32'h0, 64'h0, 4'd1, 64'h0));
		issue(mk(FUNC_ADD, '1, '1, 4'd8, 64'h0));
		issue(mk(FUNC_FIND, '1, '1, 4'd8, '1));
		issue(mk(FUNC_ADD, 32'h0, 64'h11, 4'd1, 64'h1111));
		issue(mk(FUNC_ADD, 32'h0, 64'h22, 4'd0, 64'h2222));
		issue(mk(FUNC_ADD, 32'h0, 64'h33, 4'd9, 64'h3333));
		issue(mk(FUNC_ADD, 32'h0, 64'h44, 4'd15, 64'h4444));
		issue(mk(FUNC_FIND, 32'h0, 64'h33, 4'd9, 64'h0));
		issue(mk(FUNC_DEL, 32'h0, 64'h0, 4'd1, 64'h0));
		issue(mk(FUNC_FIND, 32'h0, 64'h11, 4'd1, 64'h0));
		issue(mk(FUNC_DEL, 32'h0, 64'h0, 4'd1, 64'h0));
		issue(mk(FUNC_RSVD, 32'h0, 64'h11, 4'd1, '1));
		drain();
		reg_write(REG_CASE, 32'd1);
		reg_write(REG_BITS, 32'd1);
		issue(mk(FUNC_ADD, 32'h7, 64'h4142, 4'd2, 64'hA));
		issue(mk(FUNC_ADD, 32'h9, 64'h4344, 4'd2, 64'hB));
		issue(mk(FUNC_ADD, 32'hB, 64'h4546, 4'd2, 64'hC));
		issue(mk(FUNC_FIND, 32'h7, 64'h6162, 4'd2, 64'h0));
		issue(mk(FUNC_ADD, 32'h9, 64'h6364, 4'd2, 64'hD));
		issue(mk(FUNC_DEL, 32'h7, 64'h6142, 4'd2, 64'h0));

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			reg_write(REG_CASE, ph[0] ? 32'd0 : 32'd1);
			reg_write(REG_BITS, {28'd0, bits_list[ph]});
			refill_pool();
			idle_pct = pct_list[ph % 4];
			for (int n = 0; n < 240; n++) begin
				if ($urandom_range(99) < 80)
					issue(pool_req());
				else
					issue(mk(2'($urandom_range(2)), $urandom, rand64(),
						4'($urandom_range(1, 8)), rand64()));
				if (n == 120) drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests with %0d register writes across eight table settings,",
			sent, cfg_writes);
		$display("covering finds, adds, deletes, full tables, folded keys and idle gaps.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
